FILE: rtl/core/mips_instruction_executor_core_defines.svh
// assertion macros for the executor core
`ifndef MIPS_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define MIPS_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define MIE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mie assertion failed");
`define MIE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("mie assertion failed");
`else
`define MIE_ASSERT(lbl, prop)
`define MIE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/core/mie_pkg.sv
// types and opcode constants for the executor core
package mie_pkg;
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ILLEGAL = 2'd1,
		ST_BADMEM  = 2'd2,
		ST_SYSCALL = 2'd3
	} status_t;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_XORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2b;

	// function codes under the special opcode
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0c;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2a;
	localparam logic [5:0] FN_SLTU    = 6'h2b;

	localparam logic [4:0] LINK_REG = 5'd31;
endpackage

FILE: rtl/core/mips_instruction_executor_core.sv
// Executes one MIPS32 subset instruction per beat against an internal register file, PC,
// HI/LO and little-endian data memory of MEM_BYTES bytes. An instruction is accepted, reads
// its operands from the register-file ram in the next cycle, computes and commits PC, HI/LO
// and stores, then issues its load and delivers the result from the output stage in the next
// cycle; a new instruction can be taken every cycle while the output is not stalled. Results
// of the instruction in the output stage and of the last register write are forwarded to the
// operand stage. After reset the data memory is cleared one word per cycle, all (MEM_BYTES+3)/4
// words, during which in_stall is held high.
`include "mips_instruction_executor_core_defines.svh"
module mips_instruction_executor_core
	import mie_pkg::*;
#(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value
);
	localparam int MEM_WORDS = (MEM_BYTES + 3) / 4;
	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	// handshake and pipeline control
	logic in_acc, s1_go;
	logic v_s1, s2_v, pend_s2;
	logic clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	// architectural registers
	logic [31:0] pc_q, hi_q, lo_q;
	logic [31:0] gpr_vld_q;
	logic        lw_v_q;
	logic [4:0]  lw_idx_q;
	logic [31:0] lw_val_q;

	// stage 1 registers
	logic [31:0] instr_s1;
	logic [31:0] ra_data, rb_data;
	logic        gpr_re;
	logic [4:0]  ra_addr, rb_addr;

	// stage 2 registers
	status_t     st_s2;
	logic [31:0] npc_s2, val_s2;
	logic        wr_s2, ld_s2;
	logic [4:0]  dst_s2;
	logic [5:0]  op_s2;
	logic [1:0]  off_s2;

	// data memory lanes
	logic [3:0]  lane_we;
	logic [31:0] dm_wdata, dm_rdata;
	logic [AW-1:0] dm_waddr, dm_raddr;
	logic        dm_re;

	// gpr write port
	logic        gpr_we;
	logic [31:0] wb_val;

	assign s1_go    = v_s1 && (!s2_v || !out_stall);
	assign in_stall = clr_busy_q || (v_s1 && !s1_go);
	assign in_acc   = in_valid && !in_stall;

	// operand read: new beat on accept, re-read every cycle a beat waits in stage 1
	assign gpr_re  = in_acc || v_s1;
	assign ra_addr = in_acc ? instr_word[25:21] : instr_s1[25:21];
	assign rb_addr = in_acc ? instr_word[20:16] : instr_s1[20:16];

	// register file, one copy per read port
	mie_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
		.clk(clk), .we(gpr_we), .waddr(dst_s2), .wdata(wb_val),
		.re(gpr_re), .raddr(ra_addr), .rdata(ra_data)
	);
	mie_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
		.clk(clk), .we(gpr_we), .waddr(dst_s2), .wdata(wb_val),
		.re(gpr_re), .raddr(rb_addr), .rdata(rb_data)
	);

	// data memory, one byte lane per instance
	for (genvar g = 0; g < 4; g++) begin : g_lane
		mie_ram #(.WIDTH(8), .DEPTH(MEM_WORDS)) u_dm (
			.clk(clk), .we(lane_we[g]), .waddr(dm_waddr), .wdata(dm_wdata[8*g +: 8]),
			.re(dm_re), .raddr(dm_raddr), .rdata(dm_rdata[8*g +: 8])
		);
	end

	// load data extraction in the output stage
	logic [31:0] ld_shift, ld_val;
	always_comb begin
		ld_shift = dm_rdata >> {off_s2, 3'b000};
		case (op_s2)
			OP_LB:   ld_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
			OP_LBU:  ld_val = {24'b0, ld_shift[7:0]};
			OP_LH:   ld_val = {{16{ld_shift[15]}}, ld_shift[15:0]};
			OP_LHU:  ld_val = {16'b0, ld_shift[15:0]};
			default: ld_val = dm_rdata;
		endcase
	end
	assign wb_val = ld_s2 ? ld_val : val_s2;
	assign gpr_we = pend_s2 && wr_s2;

	// operand forwarding
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [31:0] a, b;
	assign op = instr_s1[31:26];
	assign fn = instr_s1[5:0];
	assign rs = instr_s1[25:21];
	assign rt = instr_s1[20:16];
	assign rd = instr_s1[15:11];
	assign sh = instr_s1[10:6];
	always_comb begin
		if (s2_v && wr_s2 && dst_s2 == rs) begin
			a = wb_val;
		end else if (lw_v_q && lw_idx_q == rs) begin
			a = lw_val_q;
		end else begin
			a = gpr_vld_q[rs] ? ra_data : 32'd0;
		end
		if (s2_v && wr_s2 && dst_s2 == rt) begin
			b = wb_val;
		end else if (lw_v_q && lw_idx_q == rt) begin
			b = lw_val_q;
		end else begin
			b = gpr_vld_q[rt] ? rb_data : 32'd0;
		end
	end

	// execute in stage 1
	logic [31:0] imm_s, imm_z, pc4, npc, val, addr, jtgt, btgt;
	logic [4:0]  dst;
	logic        wr, is_ld, is_st, is_mul, mem_bad, wr_fin;
	logic [2:0]  msize;
	logic [32:0] mend;
	status_t     st;
	logic signed [63:0] prod_s;
	logic [63:0] prod_u;
	always_comb begin
		imm_s  = {{16{instr_s1[15]}}, instr_s1[15:0]};
		imm_z  = {16'b0, instr_s1[15:0]};
		pc4    = pc_q + 32'd4;
		jtgt   = {pc4[31:28], instr_s1[25:0], 2'b00};
		btgt   = pc4 + {imm_s[29:0], 2'b00};
		addr   = a + imm_s;
		prod_s = $signed(a) * $signed(b);
		prod_u = {32'b0, a} * {32'b0, b};
		npc    = pc4;
		val    = 32'd0;
		dst    = rt;
		wr     = 1'b0;
		st     = ST_OK;
		is_ld  = 1'b0;
		is_st  = 1'b0;
		is_mul = 1'b0;
		msize  = 3'd4;
		if (op == OP_SPECIAL) begin
			dst = rd;
			wr  = 1'b1;
			case (fn)
				FN_SLL:     val = b << sh;
				FN_SRL:     val = b >> sh;
				FN_SRA:     val = 32'($signed(b) >>> sh);
				FN_JR:      begin wr = 1'b0; npc = a; end
				FN_JALR:    begin val = pc4; npc = a; end
				FN_SYSCALL: begin wr = 1'b0; st = ST_SYSCALL; end
				FN_MFHI:    val = hi_q;
				FN_MFLO:    val = lo_q;
				FN_MULT:    begin wr = 1'b0; is_mul = 1'b1; end
				FN_MULTU:   begin wr = 1'b0; is_mul = 1'b1; end
				FN_ADDU:    val = a + b;
				FN_SUBU:    val = a - b;
				FN_AND:     val = a & b;
				FN_OR:      val = a | b;
				FN_XOR:     val = a ^ b;
				FN_NOR:     val = ~(a | b);
				FN_SLT:     val = {31'b0, $signed(a) < $signed(b)};
				FN_SLTU:    val = {31'b0, a < b};
				default:    begin wr = 1'b0; st = ST_ILLEGAL; end
			endcase
		end else begin
			case (op)
				OP_J:     npc = jtgt;
				OP_JAL:   begin wr = 1'b1; dst = LINK_REG; val = pc4; npc = jtgt; end
				OP_BEQ:   if (a == b) npc = btgt;
				OP_BNE:   if (a != b) npc = btgt;
				OP_ADDIU: begin wr = 1'b1; val = a + imm_s; end
				OP_SLTI:  begin wr = 1'b1; val = {31'b0, $signed(a) < $signed(imm_s)}; end
				OP_SLTIU: begin wr = 1'b1; val = {31'b0, a < imm_s}; end
				OP_ANDI:  begin wr = 1'b1; val = a & imm_z; end
				OP_ORI:   begin wr = 1'b1; val = a | imm_z; end
				OP_XORI:  begin wr = 1'b1; val = a ^ imm_z; end
				OP_LUI:   begin wr = 1'b1; val = {instr_s1[15:0], 16'b0}; end
				OP_LB, OP_LBU: begin wr = 1'b1; is_ld = 1'b1; msize = 3'd1; end
				OP_LH, OP_LHU: begin wr = 1'b1; is_ld = 1'b1; msize = 3'd2; end
				OP_LW:    begin wr = 1'b1; is_ld = 1'b1; msize = 3'd4; end
				OP_SB:    begin is_st = 1'b1; msize = 3'd1; end
				OP_SH:    begin is_st = 1'b1; msize = 3'd2; end
				OP_SW:    begin is_st = 1'b1; msize = 3'd4; end
				default:  st = ST_ILLEGAL;
			endcase
		end
		// memory range and alignment
		mend    = {1'b0, addr} + {30'b0, msize};
		mem_bad = (addr == 32'd0) || (mend > MEM_LIMIT)
			|| (msize == 3'd2 && addr[0]) || (msize == 3'd4 && addr[1:0] != 2'b00);
		if ((is_ld || is_st) && mem_bad) begin
			st = ST_BADMEM;
		end
		if (st != ST_OK) begin
			wr  = 1'b0;
			npc = pc_q;
		end
		wr_fin = wr && (dst != 5'd0);
	end

	// data memory port control: clearing pass or store/load of stage 1
	always_comb begin
		dm_waddr = clr_busy_q ? clr_cnt_q : addr[AW+1:2];
		dm_raddr = addr[AW+1:2];
		dm_re    = s1_go && is_ld && st == ST_OK;
		dm_wdata = 32'd0;
		lane_we  = 4'b0000;
		if (clr_busy_q) begin
			lane_we = 4'b1111;
		end else if (s1_go && is_st && st == ST_OK) begin
			case (msize)
				3'd1: begin
					dm_wdata = {4{b[7:0]}};
					lane_we  = 4'b0001 << addr[1:0];
				end
				3'd2: begin
					dm_wdata = {2{b[15:0]}};
					lane_we  = addr[1] ? 4'b1100 : 4'b0011;
				end
				default: begin
					dm_wdata = b;
					lane_we  = 4'b1111;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			s2_v       <= 1'b0;
			pend_s2    <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			pc_q       <= 32'd0;
			hi_q       <= 32'd0;
			lo_q       <= 32'd0;
			gpr_vld_q  <= 32'd0;
			lw_v_q     <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == LAST_WORD) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go) begin
				s2_v <= 1'b1;
			end else if (!out_stall) begin
				s2_v <= 1'b0;
			end
			pend_s2 <= s1_go;
			if (s1_go) begin
				pc_q <= npc;
				if (is_mul && st == ST_OK) begin
					hi_q <= (fn == FN_MULT) ? prod_s[63:32] : prod_u[63:32];
					lo_q <= (fn == FN_MULT) ? prod_s[31:0] : prod_u[31:0];
				end
			end
			if (gpr_we) begin
				gpr_vld_q[dst_s2] <= 1'b1;
				lw_v_q            <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1 <= instr_word;
		end
		if (s1_go) begin
			st_s2  <= st;
			npc_s2 <= npc;
			wr_s2  <= wr_fin;
			dst_s2 <= wr_fin ? dst : 5'd0;
			val_s2 <= wr_fin ? val : 32'd0;
			ld_s2  <= is_ld && st == ST_OK && wr_fin;
			op_s2  <= op;
			off_s2 <= addr[1:0];
		end
		if (gpr_we) begin
			lw_idx_q <= dst_s2;
			lw_val_q <= wb_val;
		end
	end

	assign out_valid = s2_v;
	assign status    = st_s2;
	assign next_pc   = npc_s2;
	assign reg_write = wr_s2;
	assign reg_index = dst_s2;
	assign reg_value = wb_val;

	`MIE_ASSERT(a_clr_stall, clr_busy_q |-> in_stall)
	`MIE_ASSERT(a_err_nowr, (out_valid && st_s2 != ST_OK) |-> !reg_write)
	`MIE_ASSERT(a_wr_nzero, (out_valid && reg_write) |-> reg_index != 5'd0)
	`MIE_ASSERT(a_pend_s2, pend_s2 |-> s2_v)
	`MIE_ASSERT(a_clr_noitem, clr_busy_q |-> (!v_s1 && !s2_v))
endmodule

FILE: rtl/core/mie_ram.sv
// generic simple dual-port ram with registered read
module mie_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: bench/tb_mips_instruction_executor_core.sv
// self-checking bench for the mips32 subset executor core
module tb_mips_instruction_executor_core;
	import mie_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_SIZE = 65536;
	localparam int IDLE_LIMIT = 80000;
	localparam int N_RANDOM = 1500;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  idx;
		logic [31:0] val;
	} exec_res_t;

	typedef struct {
		logic [31:0] word;
		bit          fixed;
		exec_res_t   res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] instr_word;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] next_pc;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;

	mips_instruction_executor_core #(.MEM_BYTES(MEM_SIZE)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .instr_word(instr_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .next_pc(next_pc), .reg_write(reg_write),
		.reg_index(reg_index), .reg_value(reg_value)
	);

	// shadow architectural state
	logic [31:0] gpr [32];
	logic [31:0] pc_q, hi_q, lo_q;
	logic [7:0]  dmem [MEM_SIZE];

	exec_res_t   pending_q[$];
	int          mismatches;
	int          idle_cycles;

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = 1'b1;
			#10 clk = 1'b0;
		end
	end

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic bit addr_ok(logic [31:0] ad, int sz);
		return (ad % sz == 0) && ad != 0 && ({32'd0, ad} + sz <= MEM_SIZE);
	endfunction

	// predict one instruction and update shadow state
	function automatic exec_res_t execute_instr(logic [31:0] w);
		exec_res_t r;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd, sh, dst;
		logic [31:0] a, b, simm, pc4, npc, val, ad;
		logic [63:0] p;
		logic [1:0] st;
		bit wr;
		int sz;
		op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
		sh = w[10:6]; fn = w[5:0];
		a = gpr[rs]; b = gpr[rt]; simm = sx16(w[15:0]);
		pc4 = pc_q + 32'd4; npc = pc4; st = ST_OK; wr = 1'b0; val = '0; dst = rt;
		ad = a + simm; sz = 1;
		if (op == OP_SPECIAL) begin
			wr = 1'b1; dst = rd;
			case (fn)
				FN_SLL: val = b << sh;
				FN_SRL: val = b >> sh;
				FN_SRA: val = $unsigned($signed(b) >>> sh);
				FN_JR: begin wr = 1'b0; npc = a; end
				FN_JALR: begin val = pc4; npc = a; end
				FN_SYSCALL: begin wr = 1'b0; st = ST_SYSCALL; end
				FN_MFHI: val = hi_q;
				FN_MFLO: val = lo_q;
				FN_MULT: begin
					p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					wr = 1'b0; lo_q = p[31:0]; hi_q = p[63:32];
				end
				FN_MULTU: begin
					p = {32'd0, a} * {32'd0, b};
					wr = 1'b0; lo_q = p[31:0]; hi_q = p[63:32];
				end
				FN_ADDU: val = a + b;
				FN_SUBU: val = a - b;
				FN_AND: val = a & b;
				FN_OR: val = a | b;
				FN_XOR: val = a ^ b;
				FN_NOR: val = ~(a | b);
				FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
				default: begin wr = 1'b0; st = ST_ILLEGAL; end
			endcase
		end else begin
			case (op)
				OP_J: npc = {pc4[31:28], w[25:0], 2'b00};
				OP_JAL: begin
					wr = 1'b1; dst = LINK_REG; val = pc4;
					npc = {pc4[31:28], w[25:0], 2'b00};
				end
				OP_BEQ: if (a == b) npc = pc4 + (simm << 2);
				OP_BNE: if (a != b) npc = pc4 + (simm << 2);
				OP_ADDIU: begin wr = 1'b1; val = a + simm; end
				OP_SLTI: begin wr = 1'b1; val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0; end
				OP_SLTIU: begin wr = 1'b1; val = (a < simm) ? 32'd1 : 32'd0; end
				OP_ANDI: begin wr = 1'b1; val = a & {16'd0, w[15:0]}; end
				OP_ORI: begin wr = 1'b1; val = a | {16'd0, w[15:0]}; end
				OP_XORI: begin wr = 1'b1; val = a ^ {16'd0, w[15:0]}; end
				OP_LUI: begin wr = 1'b1; val = {w[15:0], 16'd0}; end
				OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
					sz = (op == OP_LB || op == OP_LBU) ? 1 : (op == OP_LW ? 4 : 2);
					if (!addr_ok(ad, sz)) st = ST_BADMEM;
					else begin
						for (int i = 0; i < sz; i++) val[8*i +: 8] = dmem[ad + i];
						if (op == OP_LB) val = {{24{val[7]}}, val[7:0]};
						if (op == OP_LH) val = sx16(val[15:0]);
						wr = 1'b1;
					end
				end
				OP_SB, OP_SH, OP_SW: begin
					sz = (op == OP_SB) ? 1 : (op == OP_SH ? 2 : 4);
					if (!addr_ok(ad, sz)) st = ST_BADMEM;
					else for (int i = 0; i < sz; i++) dmem[ad + i] = b[8*i +: 8];
				end
				default: st = ST_ILLEGAL;
			endcase
		end
		if (st != ST_OK) begin
			wr = 1'b0; npc = pc_q;
		end
		if (wr && dst == 0) wr = 1'b0;
		if (wr) gpr[dst] = val;
		else begin
			dst = '0; val = '0;
		end
		pc_q = npc;
		r.st = st; r.npc = npc; r.wr = wr; r.idx = dst; r.val = val;
		return r;
	endfunction

	// instruction encoders
	function automatic logic [31:0] r_op(logic [5:0] fn, int rs, int rt, int rd, int sh);
		return {OP_SPECIAL, rs[4:0], rt[4:0], rd[4:0], sh[4:0], fn};
	endfunction

	function automatic logic [31:0] i_op(logic [5:0] op, int rs, int rt, logic [15:0] imm);
		return {op, rs[4:0], rt[4:0], imm};
	endfunction

	// random instruction, mostly well-formed with small addresses near live data
	function automatic logic [31:0] rand_instr();
		logic [5:0] ops [20] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTI, OP_SLTIU,
			OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
			OP_SB, OP_SH, OP_SW, OP_SPECIAL};
		logic [5:0] fns [18] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_SYSCALL,
			FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU, FN_ADDU, FN_SUBU, FN_AND, FN_OR,
			FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
		logic [31:0] w;
		logic [5:0] op;
		int k;
		k = $urandom_range(0, 99);
		w = $urandom;
		if (k < 5) return w;
		op = ops[$urandom_range(0, 19)];
		if (op == OP_SPECIAL || k < 40) begin
			w[31:26] = OP_SPECIAL;
			w[5:0] = fns[$urandom_range(0, 17)];
		end else begin
			w[31:26] = op;
			// memory ops: base register is zero most of the time, small offset
			if (op >= OP_LB && $urandom_range(0, 3) != 0) begin
				w[25:21] = 5'd0;
				w[15:0] = 16'($urandom_range(0, 255));
				if ($urandom_range(0, 3) != 0) w[1:0] = 2'b00;
			end
		end
		return w;
	endfunction

	// output side: stall at random and check each beat
	initial begin
		exec_res_t exp_r, got_r;
		int gap;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if ($urandom_range(0, 2) == 0) gap = 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got_r = '{status, next_pc, reg_write, reg_index, reg_value};
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got_r);
			end else begin
				exp_r = pending_q.pop_front();
				if (got_r !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_r, got_r);
				end
			end
		end
	end

	// idle watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// send one beat and record its prediction
	task automatic send_instr(logic [31:0] w, bit fixed, exec_res_t want);
		exec_res_t pred;
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		instr_word <= w;
		do @(posedge clk); while (in_stall);
		pred = execute_instr(w);
		if (fixed && pred !== want) begin
			mismatches++;
			if (mismatches <= 10) $display("table row %h: expected %p got %p", w, want, pred);
		end
		pending_q.push_back(fixed ? want : pred);
	endtask

	initial begin
		dir_row_t rows [$];
		exec_res_t nores;
		int waited;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		instr_word <= '0;
		mismatches = 0;
		idle_cycles = 0;
		pc_q = '0; hi_q = '0; lo_q = '0;
		foreach (gpr[i]) gpr[i] = '0;
		foreach (dmem[i]) dmem[i] = '0;
		nores = '0;
		// directed table
		rows.push_back('{i_op(OP_LUI, 0, 1, 16'hffff), 1, '{ST_OK, 32'd4, 1, 5'd1, 32'hffff0000}});
		rows.push_back('{i_op(OP_ORI, 1, 1, 16'hffff), 1, '{ST_OK, 32'd8, 1, 5'd1, 32'hffffffff}});
		rows.push_back('{i_op(OP_ADDIU, 0, 0, 16'h1234), 1, '{ST_OK, 32'd12, 0, 5'd0, 32'd0}});
		rows.push_back('{32'hffffffff, 1, '{ST_ILLEGAL, 32'd12, 0, 5'd0, 32'd0}});
		rows.push_back('{r_op(6'h3f, 0, 0, 0, 0), 1, '{ST_ILLEGAL, 32'd12, 0, 5'd0, 32'd0}});
		rows.push_back('{r_op(FN_SYSCALL, 0, 0, 0, 0), 1, '{ST_SYSCALL, 32'd12, 0, 5'd0, 32'd0}});
		rows.push_back('{i_op(OP_LW, 0, 2, 16'h0000), 1, '{ST_BADMEM, 32'd12, 0, 5'd0, 32'd0}});
		rows.push_back('{i_op(OP_SW, 0, 1, 16'h0002), 1, '{ST_BADMEM, 32'd12, 0, 5'd0, 32'd0}});
		rows.push_back('{i_op(OP_SH, 0, 1, 16'h7fff), 1, '{ST_BADMEM, 32'd12, 0, 5'd0, 32'd0}});
		rows.push_back('{i_op(OP_SW, 0, 1, 16'h0010), 0, nores});
		rows.push_back('{i_op(OP_LB, 0, 3, 16'h0011), 0, nores});
		rows.push_back('{i_op(OP_LH, 0, 4, 16'h0012), 0, nores});
		rows.push_back('{i_op(OP_LBU, 0, 5, 16'h0013), 0, nores});
		rows.push_back('{i_op(OP_LHU, 0, 6, 16'h0010), 0, nores});
		rows.push_back('{i_op(OP_SB, 0, 3, 16'h7fff), 0, nores});
		rows.push_back('{i_op(OP_LW, 0, 7, 16'h7ffc), 0, nores});
		rows.push_back('{r_op(FN_SRA, 0, 1, 8, 31), 0, nores});
		rows.push_back('{r_op(FN_SRL, 0, 1, 9, 31), 0, nores});
		rows.push_back('{r_op(FN_MULT, 1, 1, 0, 0), 0, nores});
		rows.push_back('{r_op(FN_MFHI, 0, 0, 10, 0), 0, nores});
		rows.push_back('{r_op(FN_MULTU, 1, 1, 0, 0), 0, nores});
		rows.push_back('{r_op(FN_MFLO, 0, 0, 11, 0), 0, nores});
		rows.push_back('{r_op(FN_SLT, 1, 0, 12, 0), 0, nores});
		rows.push_back('{i_op(OP_BNE, 1, 0, 16'h8000), 0, nores});
		rows.push_back('{{OP_JAL, 26'h3ffffff}, 0, nores});
		repeat (9) @(posedge clk);
		arst_n = 1'b1;
		foreach (rows[i]) send_instr(rows[i].word, rows[i].fixed, rows[i].res);
		// random part, with one drain-and-hold midway
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				while (pending_q.size() != 0) @(posedge clk);
			end
			send_instr(rand_instr(), 0, nores);
		end
		in_valid <= 1'b0;
		waited = 0;
		while (pending_q.size() != 0 && waited < IDLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
